FILE: hw/rtl/gcd_lcm_common_divisors_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the GCD / LCM common divisor block
// Shared forms for the concurrent checks, clocked on clk and held off during
// reset.
// ----------------------------------------------------------------------------
`ifndef GCD_LCM_COMMON_DIVISORS_DEFINES_SVH
`define GCD_LCM_COMMON_DIVISORS_DEFINES_SVH

// Same-cycle implication.
`define GLCD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define GLCD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/gcdlcm_pkg.sv
// ----------------------------------------------------------------------------
// GCD / LCM common divisor package
// Widths, sequencer states and the request and response bundles of the
// shared divider.
// ----------------------------------------------------------------------------
package gcdlcm_pkg;

	localparam int OPERAND_WIDTH = 12;
	localparam int PROD_W        = 2 * OPERAND_WIDTH;
	localparam int DIV_CNT_W     = $clog2(PROD_W + 1);
	localparam int FIELD_W       = 12;
	localparam int LCM_W         = 24;
	localparam int MAX_RESULTS   = 48;
	localparam int RES_CNT_W     = $clog2(MAX_RESULTS);
	localparam int IN_DATA_W     = 2 * FIELD_W;
	localparam int OUT_DATA_W    = 2 * FIELD_W + LCM_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EUC_START,
		ST_EUC_WAIT,
		ST_LCM_START,
		ST_LCM_WAIT,
		ST_TRY_START,
		ST_TRY_WAIT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic                     start;
		logic                     long_div;
		logic [PROD_W-1:0]        dividend;
		logic [OPERAND_WIDTH-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                     busy;
		logic                     done;
		logic [PROD_W-1:0]        quotient;
		logic [OPERAND_WIDTH-1:0] remainder;
	} div_rsp_t;

endpackage

FILE: hw/rtl/gcdlcm_div.sv
// ----------------------------------------------------------------------------
// Shared restoring divider
// One quotient bit per cycle. A short request divides an operand-wide
// dividend in OPERAND_WIDTH steps, a long one the full product in PROD_W steps.
// ----------------------------------------------------------------------------
module gcdlcm_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gcdlcm_pkg::div_req_t req,
	output gcdlcm_pkg::div_rsp_t rsp
);
	import gcdlcm_pkg::*;

	logic                     busy_q;
	logic                     done_q;
	logic [DIV_CNT_W-1:0]     cnt_q;
	logic [OPERAND_WIDTH-1:0] den_q;
	logic [OPERAND_WIDTH-1:0] rem_q;
	logic [PROD_W-1:0]        quo_q;

	logic [OPERAND_WIDTH:0]   trial;
	logic [OPERAND_WIDTH+1:0] diff;
	logic                     fits;

	always_comb begin
		trial = {rem_q, quo_q[PROD_W-1]};
		diff  = {1'b0, trial} - {2'b00, den_q};
		fits  = !diff[OPERAND_WIDTH+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= req.long_div ? DIV_CNT_W'(PROD_W) : DIV_CNT_W'(OPERAND_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			den_q <= req.divisor;
			rem_q <= '0;
			quo_q <= req.long_div ? req.dividend
			                      : {req.dividend[OPERAND_WIDTH-1:0], {OPERAND_WIDTH{1'b0}}};
		end else if (busy_q) begin
			rem_q <= fits ? diff[OPERAND_WIDTH-1:0] : trial[OPERAND_WIDTH-1:0];
			quo_q <= {quo_q[PROD_W-2:0], fits};
		end
	end

	always_comb begin
		rsp.busy      = busy_q;
		rsp.done      = done_q;
		rsp.quotient  = quo_q;
		rsp.remainder = rem_q;
	end

endmodule

FILE: hw/rtl/gcd_lcm_common_divisors.sv
// ----------------------------------------------------------------------------
// GCD, LCM and common divisor lister
// Lists the common divisors of two operands, up to MAX_RESULTS, with GCD and LCM.
// ----------------------------------------------------------------------------
// Usage: the slave channel takes one word holding two operands. The block
// then drops s_tready and works on that pair alone. For a valid pair it sends
// one master word per common divisor, in ascending order from 1 up to the
// GCD, at most MAX_RESULTS of them; each word also carries the GCD and LCM,
// and m_tlast marks the final word of the pair. If either operand is zero,
// a single word with all fields zero, m_tuser set and m_tlast set is sent.
// Sequencing: every step runs through one shared restoring divider that
// retires one quotient bit per cycle. Each Euclid step and each trial divisor
// is a short division, the LCM a long division of the product by the GCD,
// and each divisor found loads the output register. A zero operand goes
// straight to the output word without any division.
// Stalls: results sit in one output register; when m_tready is low the
// sequencer holds before the next divisor until the register frees up. The
// block takes a new pair while the last word of the previous one still waits.
// Reset clears the sequencer and the output valid; no clearing pass.
// ----------------------------------------------------------------------------
module gcd_lcm_common_divisors (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// operand_a [11:0], operand_b [23:12]
	input  logic [gcdlcm_pkg::IN_DATA_W-1:0]  s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// common_divisor [11:0], gcd_value [23:12], lcm_value [47:24]
	output logic [gcdlcm_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                              m_tlast,
	// input_error [0]
	output logic                              m_tuser
);
	import gcdlcm_pkg::*;
	`include "gcd_lcm_common_divisors_defines.svh"

	state_t state_q, state_d;

	div_req_t div_req;
	div_rsp_t div_rsp;

	// Working registers of the sequencer.
	logic [OPERAND_WIDTH-1:0] x_q, y_q, g_q, d_q;
	logic [PROD_W-1:0]        prod_q, lcm_q;
	logic [RES_CNT_W-1:0]     n_q;
	logic                     err_q;

	// Output register.
	logic                     out_valid_q;
	logic [FIELD_W-1:0]       out_div_q, out_gcd_q;
	logic [LCM_W-1:0]         out_lcm_q;
	logic                     out_last_q, out_err_q;

	logic [OPERAND_WIDTH-1:0] op_a, op_b;
	logic                     accept, slot_free, emit_go, last_now;

	assign op_a      = s_tdata[OPERAND_WIDTH-1:0];
	assign op_b      = s_tdata[FIELD_W +: OPERAND_WIDTH];
	assign accept    = s_tvalid && s_tready;
	assign slot_free = !out_valid_q || m_tready;
	assign last_now  = err_q || (d_q == g_q) || (n_q == RES_CNT_W'(MAX_RESULTS - 1));

	gcdlcm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and the request to the shared divider.
	always_comb begin
		state_d          = state_q;
		s_tready         = 1'b0;
		emit_go          = 1'b0;
		div_req.start    = 1'b0;
		div_req.long_div = 1'b0;
		div_req.dividend = PROD_W'(x_q);
		div_req.divisor  = y_q;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = (op_a == '0 || op_b == '0) ? ST_EMIT : ST_EUC_START;
				end
			end
			ST_EUC_START: begin
				div_req.start = 1'b1;
				state_d       = ST_EUC_WAIT;
			end
			ST_EUC_WAIT: begin
				if (div_rsp.done) begin
					state_d = (div_rsp.remainder == '0) ? ST_LCM_START : ST_EUC_START;
				end
			end
			ST_LCM_START: begin
				div_req.start    = 1'b1;
				div_req.long_div = 1'b1;
				div_req.dividend = prod_q;
				div_req.divisor  = g_q;
				state_d          = ST_LCM_WAIT;
			end
			ST_LCM_WAIT: begin
				if (div_rsp.done) begin
					state_d = ST_TRY_START;
				end
			end
			ST_TRY_START: begin
				div_req.start    = 1'b1;
				div_req.dividend = PROD_W'(g_q);
				div_req.divisor  = d_q;
				state_d          = ST_TRY_WAIT;
			end
			ST_TRY_WAIT: begin
				if (div_rsp.done) begin
					state_d = (div_rsp.remainder == '0) ? ST_EMIT : ST_TRY_START;
				end
			end
			ST_EMIT: begin
				if (slot_free) begin
					emit_go = 1'b1;
					state_d = last_now ? ST_IDLE : ST_TRY_START;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer data path. Euclid keeps the pair in x and y; once the
	// remainder is zero, g holds the GCD.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					x_q    <= op_a;
					y_q    <= op_b;
					prod_q <= op_a * op_b;
					err_q  <= (op_a == '0) || (op_b == '0);
				end
			end
			ST_EUC_WAIT: begin
				if (div_rsp.done) begin
					x_q <= y_q;
					y_q <= div_rsp.remainder;
					g_q <= y_q;
				end
			end
			ST_LCM_WAIT: begin
				if (div_rsp.done) begin
					lcm_q <= div_rsp.quotient;
					d_q   <= OPERAND_WIDTH'(1);
					n_q   <= '0;
				end
			end
			ST_TRY_WAIT: begin
				if (div_rsp.done && div_rsp.remainder != '0) begin
					d_q <= d_q + 1'b1;
				end
			end
			ST_EMIT: begin
				if (slot_free) begin
					d_q <= d_q + 1'b1;
					n_q <= n_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: loads a word when it is empty or being drained.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_div_q  <= err_q ? '0 : FIELD_W'(d_q);
			out_gcd_q  <= err_q ? '0 : FIELD_W'(g_q);
			out_lcm_q  <= err_q ? '0 : LCM_W'(lcm_q);
			out_last_q <= last_now;
			out_err_q  <= err_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_lcm_q, out_gcd_q, out_div_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_err_q;

	`GLCD_ASSERT_NOW(a_err_is_last, m_tvalid && m_tuser, m_tlast && m_tdata == '0,
		"error word must be a lone all-zero last word")
	`GLCD_ASSERT_NOW(a_div_in_range, m_tvalid && !m_tuser,
		out_div_q != '0 && out_div_q <= out_gcd_q, "divisor outside 1..gcd")
	`GLCD_ASSERT_NOW(a_div_idle_start, div_req.start, !div_rsp.busy,
		"divider started while busy")
	`GLCD_ASSERT_NEXT(a_busy_after_accept, accept, !s_tready,
		"new pair taken while the previous one is in work")

endmodule
